[sv/stau_pkg.sv]
`default_nettype none
package stau_pkg;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_VSUM = 2'd1,
        STATUS_ZERO_DT  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input point and form the operands
        logic div1_step; // one step of the segment time division
        logic div1_fix;  // saturate segment time and check it
        logic div2_init; // prepare the acceleration division
        logic div2_step; // one step of the acceleration division
        logic mul_hi;    // curvature product, high partial
        logic mul_lo;    // curvature product, low partial and sum
        logic sq_a;      // square of the transverse part
        logic sq_c;      // square of the centripetal part and sum
        logic sqrt_step; // one step of the square root
        logic finish;    // form the result and update running time
    } stau_cmd_t;

    typedef struct packed {
        logic first;   // the loaded point is a first point
        logic bad;     // status is not ok after the checks
    } stau_stat_t;

    localparam int DIV1_STEPS = 50;
    localparam int DIV2_STEPS = 41;
    localparam int SQRT_STEPS = 32;
    localparam logic [31:0] MAG_CLAMP = 32'h8000_0000;

endpackage
`default_nettype wire

[sv/stau_datapath.sv]
`default_nettype none
module stau_datapath
    import stau_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stau_cmd_t          cmd,
    input  wire logic signed [23:0] velocity,
    input  wire logic signed [23:0] curvature,
    input  wire logic [31:0]        segment_distance,
    input  wire logic               first_point,
    output stau_stat_t              stat,
    output logic [31:0]             res_time,
    output logic [39:0]             res_elapsed,
    output logic [31:0]             res_accel,
    output logic [1:0]              res_status
);

    logic signed [23:0] pv_reg, pc_reg;
    logic [39:0]        run_reg;
    logic               first_reg;
    logic [1:0]         status_reg;
    logic [24:0]        dvm_reg;
    logic               dvneg_reg;
    logic [23:0]        v0m_reg, c0m_reg;
    // segment time divider: remainder and quotient/dividend shift register
    logic [49:0]        dq_reg;
    logic [25:0]        rem_reg;
    logic [24:0]        dsor_reg;
    logic [31:0]        dt_reg;
    logic [31:0]        at_reg, ac_reg;
    logic [47:0]        vsq_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    // square root registers; the partial root is scaled by the current bit
    logic [63:0]        sn_reg;
    logic [63:0]        sr_reg;
    logic [63:0]        sbit_reg;

    logic [25:0] rem_sh;
    logic [25:0] rem_sub;
    logic [63:0] sq_sum;
    logic signed [24:0] v1e, v0e;

    assign v1e = 25'(velocity);
    assign v0e = 25'(pv_reg);
    assign rem_sh  = {rem_reg[24:0], dq_reg[49]};
    assign rem_sub = rem_sh - {1'b0, dsor_reg};
    assign sq_sum  = sn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= '0;
            pc_reg     <= '0;
            run_reg    <= '0;
            first_reg  <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            if (cmd.load)
            begin
                pv_reg    <= velocity;
                pc_reg    <= curvature;
                first_reg <= first_point;
                if (first_point)
                begin
                    run_reg <= '0;
                end
                status_reg <= ($signed(v0e + v1e) <= 0) ? STATUS_BAD_VSUM : STATUS_OK;
            end
            if (cmd.div1_fix && status_reg == STATUS_OK && dq_reg[49:32] == '0
                && dq_reg[31:0] == '0)
            begin
                status_reg <= STATUS_ZERO_DT;
            end
            if (cmd.finish && status_reg == STATUS_OK)
            begin
                run_reg <= ({1'b0, run_reg} + 41'(dt_reg) > 41'hFF_FFFF_FFFF)
                           ? 40'hFF_FFFF_FFFF : run_reg + 40'(dt_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvm_reg   <= (v1e < v0e) ? 25'(v0e - v1e) : 25'(v1e - v0e);
            dvneg_reg <= v1e < v0e;
            v0m_reg   <= pv_reg[23] ? 24'(-pv_reg) : pv_reg;
            c0m_reg   <= pc_reg[23] ? 24'(-pc_reg) : pc_reg;
            dsor_reg  <= v0e + v1e;
            dq_reg    <= {1'b0, segment_distance, 17'd0};
            rem_reg   <= '0;
        end
        else if (cmd.div1_step)
        begin
            if (!rem_sub[25])
            begin
                rem_reg <= rem_sub;
                dq_reg  <= {dq_reg[48:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dq_reg  <= {dq_reg[48:0], 1'b0};
            end
        end
        else if (cmd.div1_fix)
        begin
            dt_reg  <= (dq_reg[49:32] != '0) ? 32'hFFFF_FFFF : dq_reg[31:0];
            vsq_reg <= v0m_reg * v0m_reg;
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= 64'(vsq_reg[47:16]) * 64'(c0m_reg);
        end
        if (cmd.mul_lo)
        begin
            ac_reg <= 32'(((prod_reg + ((64'(vsq_reg[15:0]) * 64'(c0m_reg)) >> 16)) >> 16)
                          > 64'(MAG_CLAMP) ? MAG_CLAMP
                          : 32'((prod_reg + ((64'(vsq_reg[15:0]) * 64'(c0m_reg)) >> 16))
                                >> 16));
        end
        if (cmd.sq_a)
        begin
            acc_reg <= 64'(at_reg) * 64'(at_reg);
        end
        if (cmd.sq_c)
        begin
            sn_reg   <= acc_reg + 64'(ac_reg) * 64'(ac_reg);
            sr_reg   <= '0;
            sbit_reg <= 64'h4000_0000_0000_0000;
        end
        if (cmd.sqrt_step)
        begin
            if (sr_reg + sbit_reg <= sq_sum)
            begin
                sn_reg <= sq_sum - (sr_reg + sbit_reg);
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // Wide divider for the transverse acceleration: dividend up to 41 bits,
    // divisor dt 32 bits, one quotient bit per step.
    logic [40:0] wq_reg;
    logic [32:0] wr_reg;
    logic [32:0] wr_sh, wr_sub;
    assign wr_sh  = {wr_reg[31:0], wq_reg[40]};
    assign wr_sub = wr_sh - {1'b0, dt_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div2_init)
        begin
            wq_reg <= {dvm_reg, 16'd0};
            wr_reg <= '0;
        end
        else if (cmd.div2_step)
        begin
            if (!wr_sub[32])
            begin
                wr_reg <= wr_sub;
                wq_reg <= {wq_reg[39:0], 1'b1};
            end
            else
            begin
                wr_reg <= wr_sh;
                wq_reg <= {wq_reg[39:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_hi)
        begin
            at_reg <= (wq_reg[40:32] != '0 || wq_reg[31:0] > MAG_CLAMP)
                      ? MAG_CLAMP : wq_reg[31:0];
        end
    end

    logic neg;
    assign neg = dvneg_reg && (wq_reg != '0);

    assign stat        = {first_reg, status_reg != STATUS_OK};
    assign res_time    = (status_reg == STATUS_OK) ? dt_reg : 32'd0;
    assign res_elapsed = run_reg;
    assign res_status  = status_reg;
    always_comb
    begin
        if (status_reg != STATUS_OK)
        begin
            res_accel = '0;
        end
        else if (neg)
        begin
            res_accel = (sr_reg > 64'(MAG_CLAMP)) ? MAG_CLAMP : -sr_reg[31:0];
        end
        else
        begin
            res_accel = (sr_reg > 64'(MAG_CLAMP - 32'd1)) ? MAG_CLAMP - 32'd1
                                                          : sr_reg[31:0];
        end
    end

endmodule
`default_nettype wire

[sv/stau_ctrl.sv]
`default_nettype none
module stau_ctrl
    import stau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire stau_stat_t stat,
    output stau_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV1, S_FIX, S_BADCHK, S_DIV2I, S_DIV2,
        S_MULH, S_MULL, S_SQA, S_SQC, S_SQRT, S_FIN, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (stat.first)
                    state_next = S_IDLE;
                else if (stat.bad)
                    state_next = S_OUT;
                else
                    state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div1_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV1_STEPS - 1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.div1_fix = 1'b1;
                state_next   = S_BADCHK;
            end
            S_BADCHK:
            begin
                state_next = stat.bad ? S_OUT : S_DIV2I;
            end
            S_DIV2I:
            begin
                cmd.div2_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div2_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV2_STEPS - 1))
                    state_next = S_MULH;
            end
            S_MULH:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MULL;
            end
            S_MULL:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_SQA;
            end
            S_SQA:
            begin
                cmd.sq_a   = 1'b1;
                state_next = S_SQC;
            end
            S_SQC:
            begin
                cmd.sq_c   = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[sv/segment_time_and_acceleration_unit.sv]
// Channel  | Handshake                 | Payload
// input    | in_valid / in_ready       | velocity, curvature, segment_distance, first_point
// output   | out_valid / out_ready     | segment_time, elapsed_time, acceleration, status
//
// One item at a time. A first point frees the input after its check state
// and gives no result. A normal point runs a 50-step segment time division,
// a 41-step acceleration division and a 32-step square root, one bit per
// cycle, with the check, fix, bad check, divider init, multiply, square and
// finish states around them. A bad velocity sum goes to the result from the
// check state, a zero segment time from the bad check state. Reset clears
// the previous point and running time; the result holds until its transfer,
// and no new point is taken meanwhile.
`default_nettype none
module segment_time_and_acceleration_unit
    import stau_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] velocity,
    input  wire logic signed [23:0] curvature,
    input  wire logic [31:0]        segment_distance,
    input  wire logic               first_point,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             segment_time,
    output logic [39:0]             elapsed_time,
    output logic signed [31:0]      acceleration,
    output logic [1:0]              status
);

    stau_cmd_t  cmd;
    stau_stat_t stat;

    stau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    stau_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .velocity         (velocity),
        .curvature        (curvature),
        .segment_distance (segment_distance),
        .first_point      (first_point),
        .stat             (stat),
        .res_time         (segment_time),
        .res_elapsed      (elapsed_time),
        .res_accel        (acceleration),
        .res_status       (status)
    );

    a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result waits");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_BAD_VSUM
                       || status == STATUS_ZERO_DT))
        else $error("undefined status code");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (segment_time == 32'd0
                                                && acceleration == 32'sd0))
        else $error("flagged result not zeroed");

endmodule
`default_nettype wire
